>>> rtl/lfrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrd_pkg
// Shared types and constants of the lagged-Fibonacci range draw core.
// ----------------------------------------------------------------------------
package lfrd_pkg;

  localparam int WORD_BITS       = 32;
  localparam int LONG_LAG_DEF    = 55;
  localparam int SHORT_LAG_DEF   = 31;
  localparam int MAX_REDRAWS     = 65536;
  localparam int REDRAW_BITS     = $clog2(MAX_REDRAWS);

  localparam logic [WORD_BITS-1:0] WORD_MAX = {WORD_BITS{1'b1}};

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MAX,
    ST_MUL,
    ST_READ,
    ST_SUM,
    ST_DIV_VAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic start_max;
    logic take_div;
    logic mul;
    logic read;
    logic gen;
    logic start_val;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic reject;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/lfrd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfrd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 55
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lfrd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfrd_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int CW = $clog2(WIDTH);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem, quotient[WIDTH-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(WIDTH - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
      end else begin
        rem <= trial[WIDTH-1:0];
      end
      quotient <= {quotient[WIDTH-2:0], ~diff[WIDTH]};
    end
  end

endmodule

>>> rtl/lfrd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrd_datapath
// Ring memory, lag adder, divider, scaling registers and output register.
// ----------------------------------------------------------------------------
module lfrd_datapath
  import lfrd_pkg::*;
#(
  parameter int LONG_LAG  = LONG_LAG_DEF,
  parameter int SHORT_LAG = SHORT_LAG_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [WORD_BITS-1:0] seed_word,
  input  logic [WORD_BITS-1:0] range_size,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [WORD_BITS-1:0] value,
  output logic [WORD_BITS-1:0] raw_word
);

  localparam int PW  = $clog2(LONG_LAG);
  localparam int OFS = (SHORT_LAG + LONG_LAG - 1) % LONG_LAG;

  logic [PW-1:0]          pos;
  logic [PW:0]            tap_sum;
  logic [PW-1:0]          tap_addr;
  logic [WORD_BITS-1:0]   last_word;
  logic [WORD_BITS-1:0]   rdata;
  logic [WORD_BITS-1:0]   word;
  logic [WORD_BITS-1:0]   n_reg;
  logic [WORD_BITS-1:0]   n_eff;
  logic [WORD_BITS-1:0]   divisor_reg;
  logic [WORD_BITS-1:0]   max_reg;
  logic [WORD_BITS-1:0]   raw_reg;
  logic [WORD_BITS-1:0]   product;
  logic                   ram_we;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic                   div_start;
  logic [WORD_BITS-1:0]   div_dividend;
  logic [WORD_BITS-1:0]   div_divisor;
  logic                   div_done;
  logic [WORD_BITS-1:0]   quotient;

  assign tap_sum  = {1'b0, pos} + (PW + 1)'(OFS);
  assign tap_addr = (tap_sum >= (PW + 1)'(LONG_LAG)) ?
                    PW'(tap_sum - (PW + 1)'(LONG_LAG)) : tap_sum[PW-1:0];

  // word just before the position is the last one written, once a write follows reset
  assign word      = last_word + rdata;
  assign n_eff     = (range_size == '0) ? WORD_BITS'(1) : range_size;
  // low word of the product, which never exceeds the word maximum
  assign product   = n_reg * divisor_reg;
  assign ram_we    = cmd.load | cmd.gen;
  assign ram_wdata = cmd.load ? seed_word : word;

  assign div_start    = cmd.start_max | cmd.start_val;
  assign div_dividend = cmd.start_val ? word : WORD_MAX;
  assign div_divisor  = cmd.start_val ? divisor_reg : n_eff;

  lfrd_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LONG_LAG)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (tap_addr),
    .rdata (rdata)
  );

  lfrd_div #(
    .WIDTH (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        pos <= (pos == PW'(LONG_LAG - 1)) ? '0 : pos + PW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_word <= ram_wdata;
    end
    if (cmd.start_max) begin
      n_reg <= n_eff;
    end
    if (cmd.take_div) begin
      divisor_reg <= quotient;
    end
    if (cmd.mul) begin
      max_reg <= product;
    end
    if (cmd.gen) begin
      raw_reg <= word;
    end
    if (cmd.out_load) begin
      value    <= quotient;
      raw_word <= raw_reg;
    end
  end

  assign stat.div_done = div_done;
  assign stat.reject   = (word >= max_reg);
  assign stat.out_free = !out_valid || out_ready;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < PW'(LONG_LAG - 1) || pos == PW'(LONG_LAG - 1))
    else $error("ring position out of range");

  a_accepted_below_max: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> raw_reg < max_reg)
    else $error("emitted word not below maximum");

  a_value_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> quotient < n_reg)
    else $error("scaled value not below range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("output register overwritten");

endmodule

>>> rtl/lfrd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrd_ctrl
// Sequencer for seed loads and bounded draws with rejection redraws.
// ----------------------------------------------------------------------------
module lfrd_ctrl
  import lfrd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_action,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t                 state;
  state_t                 state_next;
  logic [REDRAW_BITS-1:0] tries;
  logic [REDRAW_BITS-1:0] tries_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tries <= '0;
    end else begin
      state <= state_next;
      tries <= tries_next;
    end
  end

  always_comb begin
    state_next = state;
    tries_next = tries;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_DRAW) begin
            cmd.start_max = 1'b1;
            tries_next    = '0;
            state_next    = ST_DIV_MAX;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_DIV_MAX: begin
        if (stat.div_done) begin
          cmd.take_div = 1'b1;
          state_next   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.gen = 1'b1;
        if (stat.reject) begin
          if (tries == REDRAW_BITS'(MAX_REDRAWS - 1)) begin
            state_next = ST_IDLE;
          end else begin
            tries_next = tries + REDRAW_BITS'(1);
            state_next = ST_READ;
          end
        end else begin
          cmd.start_val = 1'b1;
          state_next    = ST_DIV_VAL;
        end
      end
      ST_DIV_VAL: begin
        if (stat.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.start_max) |-> in_valid && state == ST_IDLE)
    else $error("item taken outside idle");

  a_emit_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> $past(state) == ST_DIV_VAL || $past(state) == ST_EMIT)
    else $error("result emitted without value division");

  a_redraw_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && stat.reject && tries == REDRAW_BITS'(MAX_REDRAWS - 1))
      |=> state == ST_IDLE)
    else $error("redraw limit not honored");

endmodule

>>> rtl/lagged_fibonacci_range_draw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_fibonacci_range_draw_core
// Additive lagged-Fibonacci generator with rejection-sampled bounded draws.
// ----------------------------------------------------------------------------
// load item: taken while idle, and a new item can follow in the next cycle
// draw item: the bit-serial divider finds the scale, the next ring word is
//   summed and redrawn while rejected, then the divider scales the accepted word
// a finished result waits in the output register while the next item is taken
// reset clears the ring position, control state and the output valid flag;
//   ring contents are undefined until loaded
// ----------------------------------------------------------------------------
module lagged_fibonacci_range_draw_core
  import lfrd_pkg::*;
#(
  parameter int LONG_LAG  = LONG_LAG_DEF,
  parameter int SHORT_LAG = SHORT_LAG_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // seed_word, range_size
  input  logic [2*WORD_BITS-1:0] s_axis_tdata,
  // action
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // value, raw_word
  output logic [2*WORD_BITS-1:0] m_axis_tdata
);

  cmd_t                 cmd;
  stat_t                stat;
  logic [WORD_BITS-1:0] value;
  logic [WORD_BITS-1:0] raw_word;

  lfrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfrd_datapath #(
    .LONG_LAG  (LONG_LAG),
    .SHORT_LAG (SHORT_LAG)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .seed_word  (s_axis_tdata[WORD_BITS-1:0]),
    .range_size (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .value      (value),
    .raw_word   (raw_word)
  );

  assign m_axis_tdata = {raw_word, value};

endmodule

>>> bench/lfrd_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrd_draw_checker
// Watches both streams of the range draw core and keeps its own copy of the
// ring and write position. Every accepted load or draw item is run through
// that copy. Each draw that finds a word below the rejection ceiling queues
// one expected value and raw word. Every accepted result is compared, field
// by field, with the oldest entry in that queue. Mismatches are counted and
// handed up, along with the number of results still outstanding.
// ----------------------------------------------------------------------------
module lfrd_draw_checker
  import lfrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // seed_word, range_size
  input  logic [2*WORD_BITS-1:0] s_axis_tdata,
  // action
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // value, raw_word
  input  logic [2*WORD_BITS-1:0] m_axis_tdata,
  output int                     errors,
  output int                     outstanding
);

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [WORD_BITS-1:0] raw_word;
  } draw_result_t;

  logic [WORD_BITS-1:0] ring_words [LONG_LAG_DEF];
  int                   ring_pos = 0;
  int                   error_tally = 0;
  draw_result_t         expected_draws [$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic logic [WORD_BITS-1:0] next_ring_word();
    logic [WORD_BITS-1:0] w;
    w = ring_words[(ring_pos + LONG_LAG_DEF - 1) % LONG_LAG_DEF]
      + ring_words[(ring_pos + SHORT_LAG_DEF - 1) % LONG_LAG_DEF];
    ring_words[ring_pos] = w;
    ring_pos = (ring_pos + 1) % LONG_LAG_DEF;
    return w;
  endfunction

  task automatic predict_item(input logic act, input logic [WORD_BITS-1:0] seed,
                              input logic [WORD_BITS-1:0] bound);
    logic [WORD_BITS-1:0] n;
    logic [WORD_BITS-1:0] divisor;
    logic [WORD_BITS-1:0] ceiling;
    logic [WORD_BITS-1:0] w;
    draw_result_t         r;
    int                   tries;
    if (act == ACT_LOAD) begin
      ring_words[ring_pos] = seed;
      ring_pos = (ring_pos + 1) % LONG_LAG_DEF;
    end else begin
      // zero range behaves as one
      n = (bound == '0) ? WORD_BITS'(1) : bound;
      divisor = WORD_MAX / n;
      ceiling = n * divisor;
      // a draw that rejects too many words in a row gives no result
      for (tries = 0; tries < MAX_REDRAWS; tries++) begin
        w = next_ring_word();
        if (w < ceiling) begin
          r.value = w / divisor;
          r.raw_word = w;
          expected_draws.push_back(r);
          break;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    draw_result_t exp_r;
    draw_result_t got_r;
    if (rst) begin
      ring_pos = 0;
      expected_draws.delete();
      outstanding <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.value = m_axis_tdata[WORD_BITS-1:0];
        got_r.raw_word = m_axis_tdata[2*WORD_BITS-1:WORD_BITS];
        if (expected_draws.size() == 0) begin
          $display("%0t: result with none expected, value %h raw_word %h",
                   $time, got_r.value, got_r.raw_word);
          error_tally++;
        end else begin
          exp_r = expected_draws.pop_front();
          if (got_r.value !== exp_r.value) begin
            $display("%0t: value expected %h got %h", $time, exp_r.value, got_r.value);
            error_tally++;
          end
          if (got_r.raw_word !== exp_r.raw_word) begin
            $display("%0t: raw_word expected %h got %h",
                     $time, exp_r.raw_word, got_r.raw_word);
            error_tally++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser, s_axis_tdata[WORD_BITS-1:0],
                     s_axis_tdata[2*WORD_BITS-1:WORD_BITS]);
      outstanding <= expected_draws.size();
    end
    errors <= error_tally;
  end

endmodule

>>> bench/lagged_fibonacci_range_draw_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_fibonacci_range_draw_core_test
// Stimulus for the range draw core. The bench loads the whole ring once after
// reset and then runs directed draws over a fixed list of ranges, the extremes
// among them. It follows with a long random mix of loads and draws. Both sides
// idle at random, the output is held off for long stretches, and the input
// pauses until the core has drained. The checker beside the core predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module lagged_fibonacci_range_draw_core_test;
  import lfrd_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1200;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [WORD_BITS-1:0] DIRECTED_RANGES [14] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_000A,
    32'h0000_03E8, 32'h8000_0001
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*WORD_BITS-1:0] s_axis_tdata = '0;
  logic                   s_axis_tuser = ACT_LOAD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [2*WORD_BITS-1:0] m_axis_tdata;

  int errors;
  int outstanding;
  int items_sent = 0;
  int results_taken = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  lagged_fibonacci_range_draw_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lfrd_draw_checker draw_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  task automatic send_item(input logic act, input logic [WORD_BITS-1:0] seed,
                           input logic [WORD_BITS-1:0] bound);
    int gap;
    gap = ((items_sent / 150) % 4 == 2) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bound, seed};
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] pick_range();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(1, 16);
      3:       return $urandom_range(0, 1);
      // near half scale the rejection rate is highest
      4:       return 32'h8000_0000 + $urandom_range(0, 2) - 1;
      5:       return WORD_MAX - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [WORD_BITS-1:0] seed;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every ring entry is written before the first draw
    for (int i = 0; i < LONG_LAG_DEF; i++) begin
      case (i)
        0:       seed = '0;
        1:       seed = WORD_MAX;
        2:       seed = 32'h0000_0001;
        default: seed = $urandom();
      endcase
      send_item(ACT_LOAD, seed, $urandom());
    end

    foreach (DIRECTED_RANGES[i])
      send_item(ACT_DRAW, $urandom(), DIRECTED_RANGES[i]);
    send_item(ACT_LOAD, '0, WORD_MAX);
    send_item(ACT_LOAD, WORD_MAX, '0);
    send_item(ACT_DRAW, WORD_MAX, 32'd7);
    wait_for_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2)
        wait_for_drain();
      if ($urandom_range(0, 4) == 0)
        send_item(ACT_LOAD, $urandom(), $urandom());
      else
        send_item(ACT_DRAW, $urandom(), pick_range());
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = ((results_taken / 100) % 4 == 1) ? 0 : $urandom_range(0, 19);
      // long output hold-off so the core backs up into its input
      if (results_taken == 150 || results_taken == 900)
        gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/lfrd_pkg.sv
rtl/lfrd_ram.sv
rtl/lfrd_div.sv
rtl/lfrd_datapath.sv
rtl/lfrd_ctrl.sv
rtl/lagged_fibonacci_range_draw_core.sv
bench/lfrd_draw_checker.sv
bench/lagged_fibonacci_range_draw_core_test.sv
